FILE: rtl/fnpll_pkg.sv
// shared constants, register indexes and control types for the fractional-n word calculator
package fnpll_pkg;

  // field widths
  localparam int FREQ_W    = 32;
  localparam int PFD_W     = 27;
  localparam int VCO_MIN_W = 32;
  localparam int DIV_OUT_W = 6;
  localparam int INT_W     = 19;
  localparam int FRAC_W    = 24;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_PFD     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VCO_MIN = 1'd1;

  // register reset values
  localparam logic [PFD_W-1:0]     PFD_RESET     = 27'd42000000;
  localparam logic [VCO_MIN_W-1:0] VCO_MIN_RESET = 32'd1500000000;

  // integer part saturation value
  localparam logic [INT_W-1:0] INT_MAX = {INT_W{1'b1}};

  // parameter defaults
  localparam int MAX_DIVIDER_DEF = 62;
  localparam int FRAC_BITS_DEF   = 24;

  // controller to datapath commands
  typedef struct packed {
    logic load;         // capture request frequency, reset search
    logic search_step;  // advance divider by one step
    logic div_init;     // load dividend, clear remainder
    logic div_step;     // one restoring division step
  } fnpll_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic search_done;  // vco reached minimum or divider capped
    logic div_last;     // final division step in progress
  } fnpll_status_t;

endpackage

FILE: rtl/fnpll_ctrl.sv
// sequencing state machine for divider search, division and result strobe
module fnpll_ctrl (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  output logic                     done,
  output fnpll_pkg::fnpll_cmd_t    cmd,
  input  fnpll_pkg::fnpll_status_t status
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SEARCH = 4'b0010,
    S_DIVIDE = 4'b0100,
    S_REPORT = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (status.search_done) begin
          cmd.div_init = 1'b1;
          state_next   = S_DIVIDE;
        end else begin
          cmd.search_step = 1'b1;
        end
      end
      S_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = S_REPORT;
        end
      end
      S_REPORT: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_REPORT);

  // an accepted request keeps the block busy with no result in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done))
    else $error("accepted request did not start work");

  // a result strobe lasts exactly one cycle
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held longer than one cycle");

endmodule

FILE: rtl/fnpll_dp.sv
// datapath: config registers, divider search and restoring division
module fnpll_dp #(
  parameter int MAX_DIVIDER = fnpll_pkg::MAX_DIVIDER_DEF,
  parameter int FRAC_BITS   = fnpll_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  fnpll_pkg::fnpll_cmd_t                cmd,
  output fnpll_pkg::fnpll_status_t             status,
  input  logic [fnpll_pkg::FREQ_W-1:0]         freq_in,
  input  logic                                 cfg_we,
  input  logic [fnpll_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fnpll_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic [fnpll_pkg::DIV_OUT_W-1:0]      out_divider,
  output logic [fnpll_pkg::INT_W-1:0]          integer_part,
  output logic [fnpll_pkg::FRAC_W-1:0]         frac_part,
  output logic                                 range_error
);

  localparam int DIVW = $clog2(MAX_DIVIDER + 1);
  localparam int VW   = fnpll_pkg::FREQ_W + DIVW;
  localparam int QW   = VW + FRAC_BITS;
  localparam int CW   = $clog2(QW);
  localparam int PW   = fnpll_pkg::PFD_W;

  // configuration registers
  logic [PW-1:0]                      pfd_hz;
  logic [fnpll_pkg::VCO_MIN_W-1:0]    vco_min_hz;

  always_ff @(posedge clk) begin
    if (rst) begin
      pfd_hz     <= fnpll_pkg::PFD_RESET;
      vco_min_hz <= fnpll_pkg::VCO_MIN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        fnpll_pkg::REG_PFD:     pfd_hz     <= cfg_data[PW-1:0];
        fnpll_pkg::REG_VCO_MIN: vco_min_hz <= cfg_data[fnpll_pkg::VCO_MIN_W-1:0];
        default: ;
      endcase
    end
  end

  // search registers
  logic [fnpll_pkg::FREQ_W-1:0] freq;
  logic                         freq_zero;
  logic [DIVW-1:0]              div;
  logic [VW-1:0]                vco;
  logic                         capped;

  // division registers
  logic [QW-1:0]                quot;
  logic [PW-1:0]                rem;
  logic [CW-1:0]                cnt;

  // search step logic
  logic [DIVW:0]   div_cand;
  logic            vco_ok;
  logic            cap_hit;
  logic [VW-1:0]   addend;

  always_comb begin
    div_cand = (div == DIVW'(1)) ? (DIVW+1)'(2) : ({1'b0, div} + (DIVW+1)'(2));
    vco_ok   = (vco >= VW'(vco_min_hz));
    cap_hit  = (div_cand > (DIVW+1)'(MAX_DIVIDER));
    addend   = (div == DIVW'(1)) ? VW'(freq) : (VW'(freq) << 1);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      freq      <= freq_in;
      freq_zero <= (freq_in == '0);
      div       <= DIVW'(1);
      vco       <= VW'(freq_in);
    end else if (cmd.search_step) begin
      div <= div_cand[DIVW-1:0];
      vco <= vco + addend;
    end
  end

  // restoring division step
  logic [PW:0] r2;
  logic        ge;
  logic [PW:0] diff;

  always_comb begin
    r2   = {rem, quot[QW-1]};
    ge   = (r2 >= {1'b0, pfd_hz});
    diff = r2 - {1'b0, pfd_hz};
  end

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      quot   <= {vco, {FRAC_BITS{1'b0}}};
      rem    <= '0;
      cnt    <= '0;
      capped <= !vco_ok;
    end else if (cmd.div_step) begin
      quot <= {quot[QW-2:0], ge};
      rem  <= ge ? diff[PW-1:0] : r2[PW-1:0];
      cnt  <= cnt + CW'(1);
    end
  end

  assign status.search_done = vco_ok || cap_hit;
  assign status.div_last    = (cnt == CW'(QW - 1));

  // result formatting
  logic [VW-1:0]                        ip_full;
  logic                                 ip_sat;
  logic                                 pfd_zero;
  logic [fnpll_pkg::FRAC_W+FRAC_BITS-1:0] frac_ext;
  logic [fnpll_pkg::DIV_OUT_W+DIVW-1:0]   div_ext;

  always_comb begin
    ip_full  = quot[QW-1:FRAC_BITS];
    ip_sat   = (ip_full > VW'(fnpll_pkg::INT_MAX));
    pfd_zero = (pfd_hz == '0);
    frac_ext = {{fnpll_pkg::FRAC_W{1'b0}}, quot[FRAC_BITS-1:0]};
    div_ext  = {{fnpll_pkg::DIV_OUT_W{1'b0}}, div};
  end

  assign out_divider  = div_ext[fnpll_pkg::DIV_OUT_W-1:0];
  assign integer_part = (pfd_zero || ip_sat) ? fnpll_pkg::INT_MAX
                                             : ip_full[fnpll_pkg::INT_W-1:0];
  assign frac_part    = pfd_zero ? '0 : frac_ext[fnpll_pkg::FRAC_W-1:0];
  assign range_error  = capped || freq_zero || pfd_zero || ip_sat;

  // a search step always lands on an even divider
  a_div_even: assert property (@(posedge clk) disable iff (rst)
    cmd.search_step |=> (!div[0] && (div >= DIVW'(2))))
    else $error("search step left an odd divider");

  // division always starts from a cleared remainder and counter
  a_div_init: assert property (@(posedge clk) disable iff (rst)
    cmd.div_init |=> ((rem == '0) && (cnt == '0)))
    else $error("division did not start clean");

endmodule

FILE: rtl/frac_n_pll_word_calculator.sv
// top level: fractional-n synthesizer word calculator
// sequence: an accepted request runs k divider search steps (0 to MAX_DIVIDER/2), then a
//   restoring division with a (32 + clog2(MAX_DIVIDER+1) + FRAC_BITS)-bit quotient, then done
// throughput: one request at a time, set by the one-bit-per-cycle restoring divider;
//   the next request is taken the cycle after done
// reset: synchronous, returns to idle and loads pfd_hz 42000000 and vco_min_hz 1500000000
// done lasts one cycle; the receiver cannot stall
module frac_n_pll_word_calculator #(
  parameter int MAX_DIVIDER = fnpll_pkg::MAX_DIVIDER_DEF,
  parameter int FRAC_BITS   = fnpll_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [fnpll_pkg::FREQ_W-1:0]     freq_hz,
  output logic                             done,
  output logic [fnpll_pkg::DIV_OUT_W-1:0]  out_divider,
  output logic [fnpll_pkg::INT_W-1:0]      integer_part,
  output logic [fnpll_pkg::FRAC_W-1:0]     frac_part,
  output logic                             range_error,
  input  logic                             cfg_we,
  input  logic [fnpll_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fnpll_pkg::CFG_DATA_W-1:0] cfg_data
);

  fnpll_pkg::fnpll_cmd_t    cmd;
  fnpll_pkg::fnpll_status_t status;

  // sequencing
  fnpll_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .cmd    (cmd),
    .status (status)
  );

  // arithmetic
  fnpll_dp #(
    .MAX_DIVIDER (MAX_DIVIDER),
    .FRAC_BITS   (FRAC_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .freq_in      (freq_hz),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .out_divider  (out_divider),
    .integer_part (integer_part),
    .frac_part    (frac_part),
    .range_error  (range_error)
  );

endmodule
